### rtl/core/bphc_pkg.sv
// ----------------------------------------------------------------------------
// bphc_pkg
// Types, codes and constants shared by the bitplane to pixel converter.
// ----------------------------------------------------------------------------
`default_nettype none

package bphc_pkg;

  localparam int PLANE_W   = 16;
  localparam int PIXELS    = 16;
  localparam int IDX_W     = 6;
  localparam int COLOUR_W  = 32;
  localparam int BEAT_W    = 5;

  localparam logic [1:0] REG_DISPLAY_MODE = 2'd0;

  localparam logic [1:0] MODE_HIRES = 2'd0;
  localparam logic [1:0] MODE_LORES = 2'd1;
  localparam logic [1:0] MODE_HAM6  = 2'd2;

  localparam logic ITEM_CONVERT = 1'b0;
  localparam logic ITEM_PALETTE = 1'b1;

  localparam logic [COLOUR_W-1:0] KEEP_NO_BLUE  = 32'hFFFFFF00;
  localparam logic [COLOUR_W-1:0] KEEP_NO_RED   = 32'hFF00FFFF;
  localparam logic [COLOUR_W-1:0] KEEP_NO_GREEN = 32'hFFFF00FF;

  localparam logic [BEAT_W-1:0] LAST_BEAT_HIRES = 5'd15;
  localparam logic [BEAT_W-1:0] LAST_BEAT_LORES = 5'd31;

  typedef enum logic [1:0] {
    HAM_PALETTE = 2'd0,
    HAM_BLUE    = 2'd1,
    HAM_RED     = 2'd2,
    HAM_GREEN   = 2'd3
  } ham_ctrl_t;

  typedef struct packed {
    logic                              is_write;
    logic [PIXELS-1:0][IDX_W-1:0]      pix_idx;
    logic [IDX_W-1:0]                  entry_index;
    logic [COLOUR_W-1:0]               entry_colour;
  } queue_entry_t;

  // screen pixel to bit position inside a byte-swapped plane word
  function automatic logic [3:0] pixel_bit(input int p);
    logic [4:0] pos;
    pos = (p < 8) ? 5'(7 - p) : 5'(23 - p);
    return pos[3:0];
  endfunction

endpackage

`default_nettype wire

### rtl/core/bphc_if.sv
// ----------------------------------------------------------------------------
// bphc_item_if / bphc_pix_if
// Valid/ready channels for plane word sets and for output pixels.
// ----------------------------------------------------------------------------
`default_nettype none

interface bphc_item_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] plane_a;
  logic [15:0] plane_b;
  logic [15:0] plane_c;
  logic [15:0] plane_d;
  logic [15:0] plane_e;
  logic [15:0] plane_f;
  logic [5:0]  entry_index;
  logic [31:0] entry_colour;

  modport source (
    output valid, mode, plane_a, plane_b, plane_c, plane_d, plane_e, plane_f,
           entry_index, entry_colour,
    input  ready
  );
  modport sink (
    input  valid, mode, plane_a, plane_b, plane_c, plane_d, plane_e, plane_f,
           entry_index, entry_colour,
    output ready
  );
endinterface

interface bphc_pix_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_colour;
  logic        last_pixel;

  modport source (output valid, pixel_colour, last_pixel, input ready);
  modport sink (input valid, pixel_colour, last_pixel, output ready);
endinterface

`default_nettype wire

### rtl/core/bphc_front.sv
// ----------------------------------------------------------------------------
// bphc_front
// Accepts items, splits plane words into per-pixel palette indices.
// ----------------------------------------------------------------------------
`default_nettype none

module bphc_front
  import bphc_pkg::*;
(
  bphc_item_if.sink           item,
  input  wire logic [1:0]     display_mode,
  input  wire logic           queue_full,
  output logic                push,
  output queue_entry_t        push_entry
);

  logic [3:0] pos;

  assign item.ready = !queue_full;
  assign push       = item.valid && !queue_full;

  always_comb begin
    pos = '0;
    push_entry.is_write     = (item.mode == ITEM_PALETTE);
    push_entry.entry_index  = item.entry_index;
    push_entry.entry_colour = item.entry_colour;
    for (int p = 0; p < PIXELS; p++) begin
      pos = pixel_bit(p);
      push_entry.pix_idx[p] = {item.plane_f[pos], item.plane_e[pos], item.plane_d[pos],
                               item.plane_c[pos], item.plane_b[pos], item.plane_a[pos]};
      if (display_mode == MODE_HIRES) begin
        push_entry.pix_idx[p][5:4] = 2'b00;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/bphc_queue.sv
// ----------------------------------------------------------------------------
// bphc_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module bphc_queue
  import bphc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire queue_entry_t push_entry,
  output logic              full,
  input  wire logic         pop,
  output logic              head_valid,
  output queue_entry_t      head
);

  queue_entry_t slots [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/bphc_back.sv
// ----------------------------------------------------------------------------
// bphc_back
// Palette memory, pixel sequencer, HAM colour update and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bphc_back
  import bphc_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 64
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic [1:0]   display_mode,
  input  wire logic         head_valid,
  input  wire queue_entry_t head,
  output logic              pop,
  bphc_pix_if.source        pixel
);

  localparam int         AW        = $clog2(PALETTE_ENTRIES);
  localparam logic [6:0] ENTRIES_W = 7'(PALETTE_ENTRIES);

  logic [COLOUR_W-1:0]        mem [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0] entry_vld;

  logic [BEAT_W-1:0]   beat;
  logic [BEAT_W-1:0]   last_beat;
  logic                lores;
  logic                ham;
  logic                wr_en;
  logic                wr_in_range;
  logic                issue;
  logic                issue_last;
  logic [3:0]          pix_sel;
  logic [IDX_W-1:0]    cur_idx;
  logic                rd_in_range;

  logic                s2_valid;
  logic                s2_adv;
  logic                s2_load;
  logic [IDX_W-1:0]    s2_idx;
  logic                s2_last;
  logic [COLOUR_W-1:0] rd_data;
  logic                rd_ok;

  logic                out_valid;
  logic                out_load;
  logic [COLOUR_W-1:0] out_colour;
  logic                out_last;
  logic [COLOUR_W-1:0] last_colour;
  logic [COLOUR_W-1:0] pal_colour;
  logic [COLOUR_W-1:0] colour;
  logic [7:0]          nib2;
  ham_ctrl_t           ctrl;

  assign lores      = (display_mode != MODE_HIRES);
  assign ham        = display_mode[1];
  assign last_beat  = lores ? LAST_BEAT_LORES : LAST_BEAT_HIRES;
  assign pix_sel    = lores ? beat[4:1] : beat[3:0];
  assign cur_idx    = head.pix_idx[pix_sel];

  assign wr_en       = head_valid && head.is_write;
  assign wr_in_range = ({1'b0, head.entry_index} < ENTRIES_W);
  assign rd_in_range = ({1'b0, cur_idx} < ENTRIES_W);

  assign out_load   = !out_valid || pixel.ready;
  assign s2_adv     = s2_valid && out_load;
  assign s2_load    = !s2_valid || s2_adv;
  assign issue      = head_valid && !head.is_write && s2_load;
  assign issue_last = issue && (beat == last_beat);
  assign pop        = wr_en || issue_last;

  // palette storage
  always_ff @(posedge clk) begin
    if (wr_en && wr_in_range) begin
      mem[head.entry_index[AW-1:0]] <= head.entry_colour;
    end
    if (issue && rd_in_range) begin
      rd_data <= mem[cur_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_vld <= '0;
    end else if (wr_en && wr_in_range) begin
      entry_vld[head.entry_index[AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_ok   <= rd_in_range && entry_vld[cur_idx[AW-1:0]];
      s2_idx  <= cur_idx;
      s2_last <= (beat == last_beat);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat     <= '0;
      s2_valid <= 1'b0;
    end else begin
      if (issue_last) begin
        beat <= '0;
      end else if (issue) begin
        beat <= beat + 5'd1;
      end
      if (s2_load) begin
        s2_valid <= issue;
      end
    end
  end

  always_comb begin
    ctrl       = ham_ctrl_t'(s2_idx[5:4]);
    nib2       = {s2_idx[3:0], s2_idx[3:0]};
    pal_colour = rd_ok ? rd_data : '0;
    colour     = pal_colour;
    if (ham) begin
      case (ctrl)
        HAM_BLUE:  colour = (last_colour & KEEP_NO_BLUE)  | {24'h0, nib2};
        HAM_RED:   colour = (last_colour & KEEP_NO_RED)   | {8'h0, nib2, 16'h0};
        HAM_GREEN: colour = (last_colour & KEEP_NO_GREEN) | {16'h0, nib2, 8'h0};
        default:   colour = pal_colour;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      out_colour <= colour;
      out_last   <= s2_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      last_colour <= '0;
    end else begin
      if (out_load) begin
        out_valid <= s2_valid;
      end
      if (s2_adv) begin
        last_colour <= colour;
      end
    end
  end

  assign pixel.valid        = out_valid;
  assign pixel.pixel_colour = out_colour;
  assign pixel.last_pixel   = out_last;

endmodule

`default_nettype wire

### rtl/core/bitplane_to_pixel_ham_converter_unit.sv
// ----------------------------------------------------------------------------
// bitplane_to_pixel_ham_converter_unit
// Planar to chunky converter with hires, lores and HAM6 modes.
//
// Each word set turns six 16-bit plane words into chunky 0xAARRGGBB pixels,
// one beat per cycle on the pixel channel unless the output stalls: 16 beats
// in hires, 32 in lores and HAM6, the rate set by the output channel and the
// single read port of the palette memory. A palette write item is taken by
// the back end and yields no beat. A two-entry queue lets the next items be
// taken while a word set streams out; each pixel passes the queue, the
// palette read register and the output register. The palette reads zero
// after reset without a clearing pass. display_mode sits at address 0; the
// user must write it only while the unit is idle; the unit does not check.
// ----------------------------------------------------------------------------
`default_nettype none

module bitplane_to_pixel_ham_converter_unit
  import bphc_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  bphc_item_if.sink        item,
  bphc_pix_if.source       pixel,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [1:0]   display_mode;
  logic         push;
  queue_entry_t push_entry;
  logic         queue_full;
  logic         pop;
  logic         head_valid;
  queue_entry_t head;

  assign pready = 1'b1;
  assign prdata = {30'h0, display_mode};

  always_ff @(posedge clk) begin
    if (rst) begin
      display_mode <= MODE_HIRES;
    end else if (psel && penable && pwrite && pready && (paddr == REG_DISPLAY_MODE)) begin
      display_mode <= pwdata[1:0];
    end
  end

  bphc_front u_front (
    .item         (item),
    .display_mode (display_mode),
    .queue_full   (queue_full),
    .push         (push),
    .push_entry   (push_entry)
  );

  bphc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  bphc_back #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .display_mode (display_mode),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .pixel        (pixel)
  );

endmodule

`default_nettype wire

### tb/bitplane_to_pixel_ham_converter_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bitplane_to_pixel_ham_converter_unit_test
// Drives plane word sets and palette writes into the converter through
// hires, lores and HAM6 settings, under varying input gaps and output stalls.
// A scoreboard predicts every pixel beat and checks the stream in order.
// ----------------------------------------------------------------------------

import bphc_pkg::*;

typedef struct packed {
  logic                          kind;
  logic [5:0][PLANE_W-1:0]       plane;
  logic [IDX_W-1:0]              entry_index;
  logic [COLOUR_W-1:0]           entry_colour;
} word_set_t;

typedef struct packed {
  logic [COLOUR_W-1:0] colour;
  logic                last;
} pixel_beat_t;

class pixel_scoreboard;
  logic [COLOUR_W-1:0] palette [64];
  logic [COLOUR_W-1:0] prev_colour;
  logic [1:0]          disp_mode;
  pixel_beat_t         expected_pixels [$];
  int                  mismatches;

  function new();
    for (int i = 0; i < 64; i++) palette[i] = '0;
    prev_colour = '0;
    disp_mode = MODE_HIRES;
    mismatches = 0;
  endfunction

  function void set_display_mode(logic [1:0] m);
    disp_mode = m;
  endfunction

  function logic [COLOUR_W-1:0] ham_modify(logic [IDX_W-1:0] idx);
    ham_ctrl_t           ctrl;
    logic [7:0]          dbl;
    logic [COLOUR_W-1:0] colour;
    ctrl = ham_ctrl_t'(idx[5:4]);
    dbl = {idx[3:0], idx[3:0]};
    case (ctrl)
      HAM_BLUE:  colour = (prev_colour & KEEP_NO_BLUE) | {24'h0, dbl};
      HAM_RED:   colour = (prev_colour & KEEP_NO_RED) | {8'h0, dbl, 16'h0};
      HAM_GREEN: colour = (prev_colour & KEEP_NO_GREEN) | {16'h0, dbl, 8'h0};
      default:   colour = palette[idx];
    endcase
    return colour;
  endfunction

  function void note_word_set(word_set_t w);
    int                  reps;
    logic                ham;
    logic [3:0]          pos;
    logic [IDX_W-1:0]    idx;
    logic [COLOUR_W-1:0] colour;
    pixel_beat_t         beat;
    if (w.kind == ITEM_PALETTE) begin
      palette[w.entry_index] = w.entry_colour;
      return;
    end
    ham = (disp_mode != MODE_HIRES) && disp_mode[1];
    reps = (disp_mode == MODE_HIRES) ? 1 : 2;
    for (int p = 0; p < 16; p++) begin
      pos = (p < 8) ? 4'(7 - p) : 4'(23 - p);
      for (int b = 0; b < 6; b++) idx[b] = w.plane[b][pos];
      if (disp_mode == MODE_HIRES) idx[5:4] = 2'b00;
      colour = ham ? ham_modify(idx) : palette[idx];
      for (int r = 0; r < reps; r++) begin
        beat.colour = colour;
        beat.last = (p == 15) && (r == reps - 1);
        expected_pixels.push_back(beat);
      end
      prev_colour = colour;
    end
  endfunction

  function void check_pixel(logic [COLOUR_W-1:0] colour, logic last);
    pixel_beat_t want;
    if (expected_pixels.size() == 0) begin
      if (mismatches < 10)
        $display("unexpected pixel beat: colour %h last %b", colour, last);
      mismatches++;
      return;
    end
    want = expected_pixels.pop_front();
    if (colour !== want.colour || last !== want.last) begin
      if (mismatches < 10)
        $display("pixel mismatch: expected colour %h last %b, got colour %h last %b",
                 want.colour, want.last, colour, last);
      mismatches++;
    end
  endfunction
endclass

module bitplane_to_pixel_ham_converter_unit_test;

  localparam logic [1:0] MODE_HAM6_ALIAS  = 2'd3;
  localparam int         HOLD_CYCLES      = 400;
  localparam int         DRAIN_CYCLES     = 16;
  localparam int         QUIET_LIMIT      = 4000;
  localparam int         PHASE_SETS       = 33;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int   idle_pct;
  int   stall_pct;
  logic hold_request;

  pixel_scoreboard sb;

  bphc_item_if item_if ();
  bphc_pix_if  pix_if ();

  bitplane_to_pixel_ham_converter_unit dut (
    .clk     (clk),
    .rst     (rst),
    .item    (item_if),
    .pixel   (pix_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // output side: random stalls, plus one long hold-off on request
  initial begin
    pix_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        pix_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        pix_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && pix_if.valid === 1'b1 && pix_if.ready === 1'b1)
      sb.check_pixel(pix_if.pixel_colour, pix_if.last_pixel);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((item_if.valid === 1'b1 && item_if.ready === 1'b1) ||
          (pix_if.valid === 1'b1 && pix_if.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  function automatic word_set_t make_convert(logic [15:0] a, logic [15:0] b,
                                             logic [15:0] c, logic [15:0] d,
                                             logic [15:0] e, logic [15:0] f);
    word_set_t w;
    w.kind = ITEM_CONVERT;
    w.plane = {f, e, d, c, b, a};
    w.entry_index = 6'($urandom);
    w.entry_colour = $urandom;
    return w;
  endfunction

  function automatic word_set_t make_palette(logic [5:0] idx, logic [31:0] colour);
    word_set_t w;
    w.kind = ITEM_PALETTE;
    for (int i = 0; i < 6; i++) w.plane[i] = 16'($urandom);
    w.entry_index = idx;
    w.entry_colour = colour;
    return w;
  endfunction

  function automatic word_set_t random_set();
    word_set_t w;
    w.kind = ($urandom_range(4) == 0) ? ITEM_PALETTE : ITEM_CONVERT;
    for (int i = 0; i < 6; i++) begin
      case ($urandom_range(7))
        0:       w.plane[i] = 16'h0000;
        1:       w.plane[i] = 16'hFFFF;
        default: w.plane[i] = 16'($urandom);
      endcase
    end
    w.entry_index = 6'($urandom);
    w.entry_colour = $urandom;
    return w;
  endfunction

  task automatic send_set(input word_set_t w);
    while ($urandom_range(99) < idle_pct) begin
      item_if.valid <= 1'b0;
      @(negedge clk);
    end
    item_if.valid        <= 1'b1;
    item_if.mode         <= w.kind;
    item_if.plane_a      <= w.plane[0];
    item_if.plane_b      <= w.plane[1];
    item_if.plane_c      <= w.plane[2];
    item_if.plane_d      <= w.plane[3];
    item_if.plane_e      <= w.plane[4];
    item_if.plane_f      <= w.plane[5];
    item_if.entry_index  <= w.entry_index;
    item_if.entry_colour <= w.entry_colour;
    do @(posedge clk); while (item_if.ready !== 1'b1);
    sb.note_word_set(w);
    @(negedge clk);
  endtask

  // hold valid low and let the output drain before touching registers
  task automatic drain_pixels();
    item_if.valid <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_display_mode(input logic [1:0] m);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_DISPLAY_MODE;
    pwdata  <= {30'h0, m};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    sb.set_display_mode(m);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  initial begin : stimulus
    logic [1:0] phase_mode [8];
    sb = new();
    phase_mode = '{MODE_HIRES, MODE_LORES, MODE_HAM6, MODE_HAM6_ALIAS,
                   MODE_HAM6, MODE_LORES, MODE_HAM6, MODE_HIRES};
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    idle_pct = 0;
    stall_pct = 0;
    hold_request = 1'b0;
    item_if.valid = 1'b0;
    item_if.mode = ITEM_CONVERT;
    item_if.plane_a = '0;
    item_if.plane_b = '0;
    item_if.plane_c = '0;
    item_if.plane_d = '0;
    item_if.plane_e = '0;
    item_if.plane_f = '0;
    item_if.entry_index = '0;
    item_if.entry_colour = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // HAM from reset: blue modifies a zero colour
    write_display_mode(MODE_HAM6);
    send_set(make_convert(16'hA5C3, 16'h0F0F, 16'h3C3C, 16'hFF00, 16'hFFFF, 16'h0000));
    send_set(make_palette(6'd0, 32'hFFFFFFFF));
    send_set(make_palette(6'd63, 32'h80402010));
    send_set(make_palette(6'd15, 32'h12345678));
    send_set(make_palette(6'd1, 32'h00000000));
    send_set(make_palette(6'd32, 32'hDEADBEEF));
    send_set(make_palette(6'd48, 32'hA5A5A5A5));
    send_set(make_convert(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 16'h0000, 16'hFFFF));
    send_set(make_convert(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF));
    send_set(make_convert(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_set(make_convert(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0F0F, 16'h3333));
    drain_pixels();
    write_display_mode(MODE_HAM6_ALIAS);
    send_set(make_convert(16'h8001, 16'h4002, 16'h2004, 16'h1008, 16'hFF00, 16'hF0F0));
    drain_pixels();
    write_display_mode(MODE_LORES);
    send_set(make_convert(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_set(make_convert(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_set(make_convert(16'h00FF, 16'hFF00, 16'h5555, 16'hAAAA, 16'h0000, 16'hFFFF));
    send_set(make_palette(6'd63, 32'h00000000));
    send_set(make_convert(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    drain_pixels();
    write_display_mode(MODE_HIRES);
    send_set(make_convert(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_set(make_convert(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF));
    send_set(make_convert(16'h5555, 16'hAAAA, 16'h3333, 16'hCCCC, 16'h0F0F, 16'hF0F0));
    drain_pixels();

    for (int ph = 0; ph < 8; ph++) begin
      write_display_mode(phase_mode[ph]);
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 57; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 57; end
        default: begin idle_pct = 15; stall_pct = 15; end
      endcase
      if (ph == 4) hold_request = 1'b1;
      for (int k = 0; k < PHASE_SETS; k++) send_set(random_set());
      drain_pixels();
    end

    if (sb.mismatches == 0 && sb.expected_pixels.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
